// ===== rtl/core/bump_alloc_pkg.sv =====
// Shared types and constants for the bump allocator.
// Used by bump_alloc_exec and bump_allocator_top; no dependencies.
package bump_alloc_pkg;

   localparam int ARENA_ADDR_BITS = 20;
   // Block sizes round up to this granule (power of two).
   localparam int ROUND_BYTES = 8;

   localparam int ADDR_W = 32;
   localparam int SIZE_W = 21;
   localparam int LOG2_W = 5;
   localparam int CMD_W  = 3;
   localparam int CSR_IDX_W = 1;

   localparam logic [32:0] ADDR_LIMIT = 33'(1) << ARENA_ADDR_BITS;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC   = 3'd0,
      CMD_ALIGN   = 3'd1,
      CMD_RESIZE  = 3'd2,
      CMD_FREE    = 3'd3,
      CMD_RESET   = 3'd4
   } cmd_type;

   localparam logic [CSR_IDX_W-1:0] CSR_ARENA_BASE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ARENA_BYTES = 1'd1;

   typedef enum logic {
      STATUS_OK    = 1'b0,
      STATUS_NOSPC = 1'b1
   } status_type;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [SIZE_W-1:0] request_size;
      logic [LOG2_W-1:0] align_log2;
      logic [ADDR_W-1:0] block_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] result_address;
      status_type        status;
      logic [SIZE_W-1:0] committed_bytes;
   } rsp_type;

   typedef struct packed {
      logic [SIZE_W-1:0] next_offset;
      logic [SIZE_W-1:0] last_block_offset;
   } arena_state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] arena_base;
      logic [SIZE_W-1:0] arena_bytes;
   } arena_cfg_type;

endpackage

// ===== rtl/core/bump_alloc_exec.sv =====
// Command logic of the bump allocator: one command against the arena state.
// Purely combinational; depends on bump_alloc_pkg.
module bump_alloc_exec
   import bump_alloc_pkg::*;
(
   input  req_type         req,
   input  arena_cfg_type   cfg,
   input  arena_state_type st,
   output rsp_type         rsp,
   output arena_state_type st_in
);

   logic [SIZE_W-1:0] cap;
   logic [SIZE_W:0]   round_sum;
   logic [SIZE_W:0]   rounded;
   logic [33:0]       amask;
   logic [33:0]       abs_addr;
   logic [33:0]       aligned;
   logic [33:0]       noff;
   logic              align_fit;
   logic [SIZE_W-1:0] alloc_off;
   logic [SIZE_W+1:0] alloc_end;
   logic              alloc_ok;
   logic [ADDR_W-1:0] last_addr;
   logic              match;
   logic [SIZE_W-1:0] eff_next;
   logic [SIZE_W-1:0] prev_size;
   logic [SIZE_W:0]   grow_end;
   logic              grow_ok;

   always_comb begin
      cap = ({12'd0, cfg.arena_bytes} < ADDR_LIMIT) ? cfg.arena_bytes : SIZE_W'(ADDR_LIMIT);

      round_sum = {1'b0, req.request_size} + (SIZE_W+1)'(ROUND_BYTES - 1);
      rounded   = round_sum & ~((SIZE_W+1)'(ROUND_BYTES - 1));

      amask     = (34'(1) << req.align_log2) - 34'd1;
      abs_addr  = {2'b00, cfg.arena_base} + 34'(st.next_offset);
      aligned   = (abs_addr + amask) & ~amask;
      noff      = aligned - {2'b00, cfg.arena_base};
      align_fit = noff <= 34'(cap);

      alloc_off = (cmd_type'(req.command) == CMD_ALIGN) ? noff[SIZE_W-1:0] : st.next_offset;
      alloc_end = (SIZE_W+2)'(alloc_off) + (SIZE_W+2)'(rounded);
      alloc_ok  = alloc_end <= (SIZE_W+2)'(cap);

      last_addr = cfg.arena_base + ADDR_W'(st.last_block_offset);
      match     = req.block_address == last_addr;
      eff_next  = (req.request_size == '0 && match) ? st.last_block_offset : st.next_offset;
      prev_size = eff_next - st.last_block_offset;
      grow_end  = (SIZE_W+1)'(st.last_block_offset) + (SIZE_W+1)'(req.request_size);
      grow_ok   = grow_end <= (SIZE_W+1)'(cap);

      st_in              = st;
      rsp.result_address = '0;
      rsp.status         = STATUS_OK;

      unique case (cmd_type'(req.command))
         CMD_ALLOC, CMD_ALIGN: begin
            if (cmd_type'(req.command) == CMD_ALIGN && !align_fit) begin
               rsp.status = STATUS_NOSPC;
            end else begin
               st_in.next_offset = alloc_off;
               if (alloc_ok) begin
                  st_in.last_block_offset = alloc_off;
                  st_in.next_offset       = alloc_end[SIZE_W-1:0];
                  rsp.result_address      = cfg.arena_base + ADDR_W'(alloc_off);
               end else begin
                  rsp.status = STATUS_NOSPC;
               end
            end
         end
         CMD_RESIZE: begin
            if (match) begin
               st_in.next_offset = eff_next;
               if (req.request_size > prev_size) begin
                  if (grow_ok) begin
                     st_in.next_offset  = grow_end[SIZE_W-1:0];
                     rsp.result_address = req.block_address;
                  end else begin
                     rsp.status = STATUS_NOSPC;
                  end
               end else begin
                  rsp.result_address = req.block_address;
               end
            end else if (alloc_ok) begin
               st_in.last_block_offset = alloc_off;
               st_in.next_offset       = alloc_end[SIZE_W-1:0];
               rsp.result_address      = cfg.arena_base + ADDR_W'(alloc_off);
            end else begin
               rsp.status = STATUS_NOSPC;
            end
         end
         CMD_FREE: begin
            if (match) begin
               st_in.next_offset = st.last_block_offset;
            end
         end
         CMD_RESET: begin
            st_in.next_offset       = '0;
            st_in.last_block_offset = '0;
         end
         default: begin
         end
      endcase

      rsp.committed_bytes = st_in.next_offset;
   end

endmodule

// ===== rtl/core/bump_allocator_top.sv =====
// Bump allocator top level: input register, command logic, result register.
// Depends on bump_alloc_pkg and bump_alloc_exec.
//
// One command is accepted per clock while rsp is not stalled, and each gives
// exactly one result word through the input register, then the result register;
// the command logic is a single pass of adds and compares against the offset
// registers, which update in the same cycle the result is registered. Backpressure
// on rsp stalls both stages. Usable capacity is min(arena_bytes, 2^ARENA_ADDR_BITS).
// The csr port is always ready; write it only while no command is in flight.
module bump_allocator_top
   import bump_alloc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [63:0]          req_tdata,   // request_size, align_log2, block_address, zeros
   input  logic [CMD_W-1:0]     req_tuser,   // command
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [55:0]          rsp_tdata,   // result_address, committed_bytes, zeros
   output logic [0:0]           rsp_tuser,   // status
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_data
);

   logic            in_valid_ff;
   req_type         in_ff;
   logic            out_valid_ff;
   rsp_type         out_ff;
   rsp_type         out_in;
   arena_state_type st_ff;
   arena_state_type st_in;
   arena_cfg_type   cfg_ff;
   logic            advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         in_ff.command       <= req_tuser;
         in_ff.request_size  <= req_tdata[20:0];
         in_ff.align_log2    <= req_tdata[25:21];
         in_ff.block_address <= req_tdata[57:26];
      end
   end

   bump_alloc_exec u_exec (
      .req   (in_ff),
      .cfg   (cfg_ff),
      .st    (st_ff),
      .rsp   (out_in),
      .st_in (st_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         st_ff        <= '0;
      end else begin
         if (advance) begin
            out_valid_ff <= 1'b1;
            st_ff        <= st_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ARENA_BASE:  cfg_ff.arena_base  <= csr_data;
            CSR_ARENA_BYTES: cfg_ff.arena_bytes <= csr_data[SIZE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'd0, out_ff.committed_bytes, out_ff.result_address};
   assign rsp_tuser  = out_ff.status;

   a_last_le_next: assert property (@(posedge clock) disable iff (reset)
      st_ff.last_block_offset <= st_ff.next_offset)
      else $error("last block offset above next offset");

   a_fail_no_addr: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.status == STATUS_NOSPC |-> out_ff.result_address == '0)
      else $error("failed command returned an address");

   a_reset_cmd: assert property (@(posedge clock) disable iff (reset)
      advance && cmd_type'(in_ff.command) == CMD_RESET
      |=> st_ff.next_offset == '0 && st_ff.last_block_offset == '0
          && out_ff.committed_bytes == '0)
      else $error("reset command left arena non-empty");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_ff))
      else $error("stalled command lost");

   a_committed: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_ff.committed_bytes == st_ff.next_offset)
      else $error("committed bytes disagree with next offset");

endmodule
